FILE: src/btko_pkg.sv
`timescale 1ns / 1ps
package btko_pkg;

  localparam int MaxEntriesDef = 64;
  localparam int CntW          = 7;
  localparam int IdxW          = 6;
  localparam int PidW          = 32;
  localparam int WideW         = 63;
  localparam int CpuW          = 14;
  localparam int KeyW          = 1 + CpuW + WideW + PidW;
  localparam int TokIdxW       = 8;
  localparam logic [CntW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef struct packed {
    logic [PidW-1:0]  pid;
    logic [WideW-1:0] identity;
    logic             managed;
    logic             cpu_known;
    logic [CpuW-1:0]  cpu_bp;
    logic             rss_known;
    logic [WideW-1:0] rss_size;
  } entry_t;

  // Running weakest entry handed from cell to cell
  typedef struct packed {
    logic               vld;
    logic               has;
    logic [KeyW-1:0]    key;
    logic [TokIdxW-1:0] idx;
  } tok_t;

  // Larger key ranks first: managed, cpu, rss, then lower pid
  function automatic logic [KeyW-1:0] rank_key(entry_t e);
    logic [CpuW-1:0]  c;
    logic [WideW-1:0] r;
    c = e.cpu_known ? e.cpu_bp : '0;
    r = e.rss_known ? e.rss_size : '0;
    return {e.managed, c, r, ~e.pid};
  endfunction

endpackage

FILE: src/btko_if.sv
`timescale 1ns / 1ps
interface btko_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  index;
  logic [31:0] cand_pid;
  logic [62:0] cand_identity;
  logic        cand_managed;
  logic        cand_cpu_known;
  logic [13:0] cand_cpu_bp;
  logic        cand_rss_known;
  logic [62:0] cand_rss_bytes;

  modport source (output valid, operation, index, cand_pid, cand_identity, cand_managed,
                  cand_cpu_known, cand_cpu_bp, cand_rss_known, cand_rss_bytes,
                  input ready);
  modport sink (input valid, operation, index, cand_pid, cand_identity, cand_managed,
                cand_cpu_known, cand_cpu_bp, cand_rss_known, cand_rss_bytes,
                output ready);
endinterface

interface btko_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [6:0]  entry_count;
  logic        read_valid;
  logic [31:0] out_pid;
  logic [62:0] out_identity;
  logic        out_managed;
  logic        out_cpu_known;
  logic [13:0] out_cpu_bp;
  logic        out_rss_known;
  logic [62:0] out_rss_bytes;

  modport source (output valid, accepted, entry_count, read_valid, out_pid, out_identity,
                  out_managed, out_cpu_known, out_cpu_bp, out_rss_known, out_rss_bytes,
                  input ready);
  modport sink (input valid, accepted, entry_count, read_valid, out_pid, out_identity,
                out_managed, out_cpu_known, out_cpu_bp, out_rss_known, out_rss_bytes,
                output ready);
endinterface

FILE: src/btko_cell.sv
`timescale 1ns / 1ps
module btko_cell #(
  parameter int CELL_ID = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            active_i,
  input  logic            wr_en_i,
  input  btko_pkg::entry_t wr_data_i,
  input  btko_pkg::tok_t  tok_i,
  output btko_pkg::tok_t  tok_o,
  output btko_pkg::entry_t entry_o
);

  btko_pkg::entry_t           entry_q;
  btko_pkg::tok_t             tok_d, tok_q;
  logic [btko_pkg::KeyW-1:0]  own_key;

  // Hold the stored entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_data_i;
    end
  end

  // Take this entry as weakest when active and none is held yet or it ranks strictly after the running one
  always_comb begin
    own_key = btko_pkg::rank_key(entry_q);
    tok_d   = tok_i;
    if (active_i && (!tok_i.has || (tok_i.key > own_key))) begin
      tok_d.has = 1'b1;
      tok_d.key = own_key;
      tok_d.idx = btko_pkg::TokIdxW'(CELL_ID);
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o   = tok_q;
  assign entry_o = entry_q;

endmodule

FILE: src/bounded_top_k_offer_top.sv
`timescale 1ns / 1ps
// Read, clear, no-op, non-full or zero-capacity offer: result registered next cycle.
// Offer on a full set: the weakest-entry token walks the chain of cells one cell per
// cycle, then one compare and write. One request in flight at a time; the next is
// taken once its result is registered and the output is empty or being taken.
// rst_ni (async, active low) empties the set and sets capacity to 64; entries undefined.
module bounded_top_k_offer_top #(
  parameter int MAX_ENTRIES = btko_pkg::MaxEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  btko_in_if.sink    in_ch,
  btko_out_if.source out_ch
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  btko_pkg::state_e  state_q, state_d;
  logic [btko_pkg::CntW-1:0] cap_q;
  logic [CW-1:0]     count_q, count_d, eff;
  btko_pkg::entry_t  cand_q, cand_in;
  btko_pkg::entry_t  cell_entry [MAX_ENTRIES];
  btko_pkg::tok_t    tok [MAX_ENTRIES+1];
  btko_pkg::entry_t  rd_entry;

  logic              in_acc, out_free, start_scan, wr_en, cand_load;
  logic [IW-1:0]     wr_idx;
  btko_pkg::entry_t  wr_data;
  btko_pkg::op_e     op;

  logic              ov_q, ov_d, load_out;
  logic              o_acc_d, o_acc_q, o_rv_d, o_rv_q;
  btko_pkg::entry_t  o_ent_d, o_ent_q;

  assign op       = btko_pkg::op_e'(in_ch.operation);
  assign out_free = !ov_q || out_ch.ready;
  assign in_ch.ready = (state_q == btko_pkg::ST_IDLE) && out_free;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign eff      = (int'(cap_q) < MAX_ENTRIES) ? CW'(cap_q) : CW'(MAX_ENTRIES);

  assign cand_in.pid       = in_ch.cand_pid;
  assign cand_in.identity  = in_ch.cand_identity;
  assign cand_in.managed   = in_ch.cand_managed;
  assign cand_in.cpu_known = in_ch.cand_cpu_known;
  assign cand_in.cpu_bp    = in_ch.cand_cpu_bp;
  assign cand_in.rss_known = in_ch.cand_rss_known;
  assign cand_in.rss_size  = in_ch.cand_rss_bytes;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= btko_pkg::CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Inject a fresh token at the head of the chain
  assign tok[0].vld = start_scan;
  assign tok[0].has = 1'b0;
  assign tok[0].key = '0;
  assign tok[0].idx = '0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    btko_cell #(.CELL_ID(i)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .active_i  (i < int'(eff)),
      .wr_en_i   (wr_en && (wr_idx == IW'(i))),
      .wr_data_i (wr_data),
      .tok_i     (tok[i]),
      .tok_o     (tok[i+1]),
      .entry_o   (cell_entry[i])
    );
  end

  assign rd_entry = cell_entry[IW'(in_ch.index)];

  // Next state, writes and result
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    start_scan = 1'b0;
    cand_load  = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = IW'(count_q);
    wr_data    = cand_in;
    load_out   = 1'b0;
    o_acc_d    = 1'b0;
    o_rv_d     = 1'b0;
    o_ent_d    = '0;
    case (state_q)
      btko_pkg::ST_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          case (op)
            btko_pkg::OP_OFFER: begin
              if (eff != '0) begin
                if (count_q < eff) begin
                  wr_en   = 1'b1;
                  count_d = count_q + CW'(1);
                  o_acc_d = 1'b1;
                end else begin
                  load_out   = 1'b0;
                  start_scan = 1'b1;
                  cand_load  = 1'b1;
                  state_d    = btko_pkg::ST_SCAN;
                end
              end
            end
            btko_pkg::OP_READ: begin
              if ((int'(in_ch.index) < int'(count_q)) &&
                  (int'(in_ch.index) < MAX_ENTRIES)) begin
                o_rv_d  = 1'b1;
                o_ent_d = rd_entry;
              end
            end
            btko_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      btko_pkg::ST_SCAN: begin
        wr_data = cand_q;
        wr_idx  = IW'(tok[MAX_ENTRIES].idx);
        if (tok[MAX_ENTRIES].vld) begin
          load_out = 1'b1;
          state_d  = btko_pkg::ST_IDLE;
          if (btko_pkg::rank_key(cand_q) > tok[MAX_ENTRIES].key) begin
            wr_en   = 1'b1;
            o_acc_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = btko_pkg::ST_IDLE;
      end
    endcase
    ov_d = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : ov_q);
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= btko_pkg::ST_IDLE;
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
    end
  end

  // Hold candidate and result payload
  always_ff @(posedge clk_i) begin
    if (cand_load) begin
      cand_q <= cand_in;
    end
    if (load_out) begin
      o_acc_q <= o_acc_d;
      o_rv_q  <= o_rv_d;
      o_ent_q <= o_ent_d;
    end
  end

  // Entry count follows the register after the request
  logic [CW-1:0] o_cnt_q;
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_cnt_q <= count_d;
    end
  end

  assign out_ch.valid         = ov_q;
  assign out_ch.accepted      = o_acc_q;
  assign out_ch.entry_count   = 7'(o_cnt_q);
  assign out_ch.read_valid    = o_rv_q;
  assign out_ch.out_pid       = o_ent_q.pid;
  assign out_ch.out_identity  = o_ent_q.identity;
  assign out_ch.out_managed   = o_ent_q.managed;
  assign out_ch.out_cpu_known = o_ent_q.cpu_known;
  assign out_ch.out_cpu_bp    = o_ent_q.cpu_bp;
  assign out_ch.out_rss_known = o_ent_q.rss_known;
  assign out_ch.out_rss_bytes = o_ent_q.rss_size;

endmodule
